@@ rtl/zssd_pkg.sv @@
// Package with the constants, codes and types of the zero-suppressed sequence decoder.
package zssd_pkg;

  localparam int NUM_ROWS      = 45;
  localparam int PADS_IN_ROW   = 182;
  localparam int SLOTS_PER_PAD = 512;

  localparam int CELLS   = NUM_ROWS * PADS_IN_ROW;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int CNT_W   = 10;
  localparam int ROW_W   = 7;
  localparam int PAD_W   = 8;
  localparam int TB_W    = 10;
  localparam int SLOT_W  = 9;
  localparam int ADC_W   = 16;
  localparam int LEN_W   = 5;
  localparam int WORD_W  = 16;
  localparam int CMD_W   = 2;
  localparam int OUT_DW  = 56;

  localparam logic [CMD_W-1:0] CMD_WORD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BANK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;

  localparam logic [PAD_W-1:0] PAD_BANK_END = 8'hFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_RD,
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/zero_suppressed_sequence_decoder.sv @@
// Top level of the zero-suppressed sequence decoder.
//
// Input channel (in_*): one transaction per command. in_tuser carries the
// command (sequence word, start of bank, start of event), in_tdata the
// sixteen-bit sequence word. Output channel (out_*): one transaction per
// sample of a run word, with out_tlast on the final sample of that word and
// out_tuser flagging a range error (sample not stored, slot reads zero).
// A header word, a start of bank or an ignored word leaves the block idle.
// A run word goes through ADDR, to form the pad cell address (one multiply),
// RD, for one memory read, LOAD, to load the fill count, and then EMIT, with
// one sample per cycle from the output register while out_tready stays high.
// A stall on out_tready holds the sample and the run.
// The fill counts live in one 8190 x 10 RAM. After reset and after every
// start of event the block sweeps this RAM to zero, one entry a cycle,
// and in_tready stays low until the sweep is done.
// The block works on one transaction at a time; in_tready is high only
// while it waits for the next command.
module zero_suppressed_sequence_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [zssd_pkg::WORD_W-1:0]     in_tdata,   // [15:0] seq_word
  input  logic [zssd_pkg::CMD_W-1:0]      in_tuser,   // [1:0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [zssd_pkg::OUT_DW-1:0]     out_tdata,  // row_number, pad_number,
                                                      // time_bin, slot_index,
                                                      // adc_index, zero fill
  output logic                            out_tlast,  // last_of_run
  output logic [0:0]                      out_tuser   // [0] range_error
);

  import zssd_pkg::*;

  state_t state_r, state_nxt;

  logic [CELL_AW-1:0] clr_addr_r;
  logic [CELL_AW-1:0] addr_r;
  logic               cell_ok_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ROW_W-1:0]   cur_row_r;
  logic [PAD_W-1:0]   cur_pad_r;
  logic [ADC_W-1:0]   sample_index_r;
  logic               bank_ended_r;
  logic [TB_W-1:0]    tb_r;
  logic [LEN_W-1:0]   rem_r;
  logic               lastbit_r;

  logic               out_tvalid_r;
  logic [ROW_W-1:0]   o_row_r;
  logic [PAD_W-1:0]   o_pad_r;
  logic [TB_W-1:0]    o_tb_r;
  logic [SLOT_W-1:0]  o_slot_r;
  logic [ADC_W-1:0]   o_adc_r;
  logic               o_err_r;
  logic               o_last_r;

  logic               accept;
  logic               emit_load;
  logic               store_ok;
  logic               is_run;
  logic               clr_done;
  logic               ram_we;
  logic [CELL_AW-1:0] ram_wa;
  logic [CNT_W-1:0]   ram_wd;
  logic [CNT_W-1:0]   ram_rd;
  logic               row_ok;
  logic               pad_ok;
  logic [15:0]        cell_prod;

  zssd_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CELLS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (addr_r),
    .rd_data (ram_rd)
  );

  assign accept   = in_tvalid && in_tready;
  assign is_run   = (in_tuser == CMD_WORD) && !bank_ended_r && !in_tdata[15] &&
                    (in_tdata[LEN_W-1:0] != '0);
  assign clr_done = (clr_addr_r == CELL_AW'(CELLS - 1));
  assign store_ok = cell_ok_r && (cnt_r < CNT_W'(SLOTS_PER_PAD));

  assign row_ok = (cur_row_r != '0) && (cur_row_r <= ROW_W'(NUM_ROWS));
  assign pad_ok = (cur_pad_r != '0) && (cur_pad_r <= PAD_W'(PADS_IN_ROW));
  assign cell_prod = 16'((cur_row_r - ROW_W'(1)) * 16'(PADS_IN_ROW)) +
                     16'(cur_pad_r - PAD_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_tuser == CMD_EVENT)) begin
          state_nxt = ST_CLEAR;
        end else if (accept && is_run) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_load && (rem_r == LEN_W'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    emit_load = 1'b0;
    ram_we    = 1'b0;
    ram_wa    = addr_r;
    ram_wd    = cnt_r + CNT_W'(1);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_addr_r;
        ram_wd = '0;
      end
      ST_IDLE: in_tready = 1'b1;
      ST_EMIT: begin
        emit_load = !out_tvalid_r || out_tready;
        ram_we    = emit_load && store_ok;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      cur_row_r      <= ROW_W'(1);
      cur_pad_r      <= PAD_W'(1);
      sample_index_r <= '0;
      bank_ended_r   <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_done ? '0 : clr_addr_r + CELL_AW'(1);
      end

      if (accept) begin
        case (in_tuser)
          CMD_BANK: begin
            sample_index_r <= '0;
            cur_row_r      <= ROW_W'(1);
            cur_pad_r      <= PAD_W'(1);
            bank_ended_r   <= 1'b0;
          end
          CMD_WORD: begin
            if (!bank_ended_r) begin
              if (in_tdata[15]) begin
                cur_row_r <= in_tdata[14:8];
                cur_pad_r <= in_tdata[7:0];
                if (in_tdata[7:0] == PAD_BANK_END) begin
                  bank_ended_r <= 1'b1;
                end
              end else if ((in_tdata[LEN_W-1:0] == '0) && in_tdata[5]) begin
                // An empty run with the last-of-pad bit set still moves on to the next pad.
                cur_pad_r <= cur_pad_r + PAD_W'(1);
              end
            end
          end
          default: begin
            bank_ended_r <= bank_ended_r;
          end
        endcase
      end

      if (emit_load) begin
        sample_index_r <= sample_index_r + ADC_W'(1);
        if ((rem_r == LEN_W'(1)) && lastbit_r) begin
          cur_pad_r <= cur_pad_r + PAD_W'(1);
        end
      end

      if (emit_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Run datapath and output payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      tb_r      <= TB_W'(in_tdata[14:6]);
      rem_r     <= in_tdata[LEN_W-1:0];
      lastbit_r <= in_tdata[5];
    end
    if (state_r == ST_ADDR) begin
      addr_r    <= cell_prod[CELL_AW-1:0];
      cell_ok_r <= row_ok && pad_ok;
    end
    if (state_r == ST_LOAD) begin
      cnt_r <= ram_rd;
    end
    if (emit_load) begin
      o_row_r  <= cur_row_r;
      o_pad_r  <= cur_pad_r;
      o_tb_r   <= tb_r;
      o_slot_r <= store_ok ? cnt_r[SLOT_W-1:0] : '0;
      o_adc_r  <= sample_index_r;
      o_err_r  <= !store_ok;
      o_last_r <= (rem_r == LEN_W'(1));
      tb_r     <= tb_r + TB_W'(1);
      rem_r    <= rem_r - LEN_W'(1);
      if (store_ok) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, o_adc_r, o_slot_r, o_tb_r, o_pad_r, o_row_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_err_r;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready)
    else $error("input accepted during the fill count clearing pass");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |-> (state_r == ST_EMIT))
    else $error("run ended before its last sample");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("sample presented outside a run");

  a_store_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && (state_r == ST_EMIT)) |-> (cell_ok_r && emit_load))
    else $error("fill count written for an invalid cell");
`endif

endmodule

@@ rtl/zssd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module zssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/sv/zssd_sample_check.sv @@
`timescale 1ns / 100ps
// Checker that decodes the observed command transactions and checks every decoded sample.
module zssd_sample_check (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [zssd_pkg::WORD_W-1:0] in_tdata,
  input  logic [zssd_pkg::CMD_W-1:0]  in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [zssd_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        out_tlast,
  input  logic [0:0]                  out_tuser,
  output int                          pending,
  output int                          mismatches,
  output int                          samples_seen,
  output int                          flagged_seen
);

  import zssd_pkg::*;

  localparam int PAD_LSB  = ROW_W;
  localparam int TB_LSB   = PAD_LSB + PAD_W;
  localparam int SLOT_LSB = TB_LSB + TB_W;
  localparam int ADC_LSB  = SLOT_LSB + SLOT_W;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [PAD_W-1:0]  pad;
    logic [TB_W-1:0]   tbin;
    logic [SLOT_W-1:0] slot;
    logic [ADC_W-1:0]  adc;
    logic              err;
    logic              last;
  } sample_t;

  sample_t           expected_samples[$];
  logic [CNT_W-1:0]  fill_cnt [CELLS];
  logic [ROW_W-1:0]  row_q;
  logic [PAD_W-1:0]  pad_q;
  logic [ADC_W-1:0]  adc_q;
  logic              bank_done;

  int mismatch_count = 0;
  int sample_count   = 0;
  int flag_count     = 0;

  assign mismatches   = mismatch_count;
  assign samples_seen = sample_count;
  assign flagged_seen = flag_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("[%0t] MISMATCH %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [15:0] adc);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d (sample with adc index %0d)",
                                name, got, want, adc));
    end
  endtask

  task automatic clear_counts();
    for (int i = 0; i < CELLS; i++) begin
      fill_cnt[i] = '0;
    end
  endtask

  // Expands one run word into its samples, handing out slots from the pad's fill count.
  task automatic expand_run(input logic [WORD_W-1:0] w);
    logic [8:0]       t0;
    logic [LEN_W-1:0] n;
    int               cell_idx;
    sample_t          s;
    t0 = w[14:6];
    n  = w[LEN_W-1:0];
    for (int k = 0; k < n; k++) begin
      s.row  = row_q;
      s.pad  = pad_q;
      s.tbin = TB_W'(int'(t0) + k);
      s.slot = '0;
      s.err  = 1'b1;
      s.adc  = adc_q;
      s.last = (k == n - 1);
      if (row_q >= 1 && row_q <= NUM_ROWS && pad_q >= 1 && pad_q <= PADS_IN_ROW) begin
        cell_idx = (int'(row_q) - 1) * PADS_IN_ROW + int'(pad_q) - 1;
        if (fill_cnt[cell_idx] < SLOTS_PER_PAD) begin
          s.slot = fill_cnt[cell_idx][SLOT_W-1:0];
          s.err  = 1'b0;
          fill_cnt[cell_idx] = fill_cnt[cell_idx] + 1'b1;
        end
      end
      expected_samples.push_back(s);
      adc_q = adc_q + 1'b1;
    end
    // The last-of-pad flag moves on to the next pad even for an empty run.
    if (w[5]) begin
      pad_q = pad_q + 1'b1;
    end
  endtask

  task automatic decode_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] w);
    case (cmd)
      CMD_BANK: begin
        adc_q     = '0;
        row_q     = ROW_W'(1);
        pad_q     = PAD_W'(1);
        bank_done = 1'b0;
      end
      CMD_EVENT: begin
        clear_counts();
      end
      CMD_WORD: begin
        if (!bank_done) begin
          if (w[15]) begin
            row_q = w[14:8];
            pad_q = w[PAD_W-1:0];
            if (pad_q == PAD_BANK_END) begin
              bank_done = 1'b1;
            end
          end else begin
            expand_run(w);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_sample();
    sample_t got;
    sample_t want;
    got.row  = out_tdata[ROW_W-1:0];
    got.pad  = out_tdata[PAD_LSB +: PAD_W];
    got.tbin = out_tdata[TB_LSB +: TB_W];
    got.slot = out_tdata[SLOT_LSB +: SLOT_W];
    got.adc  = out_tdata[ADC_LSB +: ADC_W];
    got.err  = out_tuser[0];
    got.last = out_tlast;
    sample_count++;
    if (got.err === 1'b1) begin
      flag_count++;
    end
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("sample with no expected sample waiting (adc index %0d)",
                                got.adc));
    end else begin
      want = expected_samples.pop_front();
      check_field("row_number", 16'(got.row), 16'(want.row), want.adc);
      check_field("pad_number", 16'(got.pad), 16'(want.pad), want.adc);
      check_field("time_bin", 16'(got.tbin), 16'(want.tbin), want.adc);
      check_field("slot_index", 16'(got.slot), 16'(want.slot), want.adc);
      check_field("adc_index", got.adc, want.adc, want.adc);
      check_field("range_error", 16'(got.err), 16'(want.err), want.adc);
      check_field("last_of_run", 16'(got.last), 16'(want.last), want.adc);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_counts();
      row_q     = ROW_W'(1);
      pad_q     = PAD_W'(1);
      adc_q     = '0;
      bank_done = 1'b0;
      expected_samples.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        compare_sample();
      end
      if (in_tvalid && in_tready) begin
        decode_command(in_tuser, in_tdata);
      end
      pending <= expected_samples.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, command stimulus, sample backpressure and the verdict.
module testbench;
  import zssd_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int ITEM_TARGET  = 230;
  localparam int EVENT_BUDGET = 6;
  localparam int FILL_RUNS    = 18;
  localparam int TAIL_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 2_000_000;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [WORD_W-1:0] in_tdata   = '0;
  logic [CMD_W-1:0]  in_tuser   = CMD_WORD;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic [0:0]        out_tuser;

  int pending;
  int mismatches;
  int samples_seen;
  int flagged_seen;

  int cycle_count = 0;
  int items_sent  = 0;
  int events_sent = 0;
  int burst_left  = 0;
  int ready_mode  = 0;
  int mode_left   = 0;
  bit bank_over   = 1'b0;

  zero_suppressed_sequence_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  zssd_sample_check u_sample_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .pending      (pending),
    .mismatches   (mismatches),
    .samples_seen (samples_seen),
    .flagged_seen (flagged_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d samples outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Sample backpressure switches between free flow, coin flips, heavy stalls and a fixed beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= (cycle_count % 5 != 0);
      endcase
    end
  end

  function automatic logic [WORD_W-1:0] header_word(input int row, input int pad);
    return {1'b1, 7'(row), 8'(pad)};
  endfunction

  function automatic logic [WORD_W-1:0] run_word(input int t0, input bit last, input int n);
    return {1'b0, 9'(t0), last, 5'(n)};
  endfunction

  // Mostly in-range rows and pads, with a share of zero and out-of-range values.
  function automatic logic [WORD_W-1:0] rand_header_word();
    int row;
    int pad;
    if ($urandom_range(0, 99) < 85) begin
      row = $urandom_range(1, NUM_ROWS);
    end else begin
      row = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(NUM_ROWS + 1, 127);
    end
    if ($urandom_range(0, 99) < 85) begin
      pad = $urandom_range(1, PADS_IN_ROW);
    end else begin
      pad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(PADS_IN_ROW + 1, 254);
    end
    return header_word(row, pad);
  endfunction

  function automatic logic [WORD_W-1:0] rand_run_word(input bit last);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      n = $urandom_range(0, 6);
    end else if (pick < 90) begin
      n = $urandom_range(7, 20);
    end else begin
      n = $urandom_range(21, 31);
    end
    return run_word($urandom_range(0, 511), last, n);
  endfunction

  // Drives one command transaction, waits for it to be taken and then maybe pauses.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] w);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!(cmd == CMD_UNUSED || (cmd == CMD_WORD && bank_over))) begin
      items_sent++;
    end
    if (cmd == CMD_EVENT) begin
      events_sent++;
    end
    if (cmd == CMD_BANK) begin
      bank_over = 1'b0;
    end else if (cmd == CMD_WORD && !bank_over && w[15] && w[PAD_W-1:0] == PAD_BANK_END) begin
      bank_over = 1'b1;
    end
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // A pad header followed by a few runs; the final run usually closes the pad.
  task automatic send_frame();
    int runs;
    runs = $urandom_range(1, 6);
    send(CMD_WORD, rand_header_word());
    for (int i = 0; i < runs; i++) begin
      if (i == runs - 1) begin
        send(CMD_WORD, rand_run_word($urandom_range(0, 9) != 0));
      end else begin
        send(CMD_WORD, rand_run_word($urandom_range(0, 9) < 3));
      end
    end
  endtask

  // Pushes more samples into one pad than it has slots for.
  task automatic fill_one_pad();
    send(CMD_WORD, header_word($urandom_range(1, NUM_ROWS), $urandom_range(1, PADS_IN_ROW)));
    repeat (FILL_RUNS) send(CMD_WORD, run_word($urandom_range(0, 511), 1'b0, 31));
  endtask

  initial begin
    int pick;
    int ignored;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(CMD_BANK, 16'h0000);
    send(CMD_WORD, run_word(0, 1'b0, 1));
    send(CMD_WORD, run_word(511, 1'b1, 31));
    send(CMD_WORD, run_word(5, 1'b1, 0));
    send(CMD_WORD, header_word(NUM_ROWS, PADS_IN_ROW));
    send(CMD_WORD, run_word(100, 1'b0, 3));
    send(CMD_WORD, header_word(0, 5));
    send(CMD_WORD, run_word(7, 1'b0, 2));
    send(CMD_WORD, header_word(NUM_ROWS + 1, 1));
    send(CMD_WORD, run_word(300, 1'b0, 1));
    send(CMD_WORD, header_word(127, 0));
    send(CMD_WORD, run_word(1, 1'b0, 2));
    send(CMD_WORD, header_word(1, PADS_IN_ROW + 1));
    send(CMD_WORD, run_word(2, 1'b0, 1));
    // Pad advance walks through 255 and wraps to zero without ending the bank.
    send(CMD_WORD, header_word(2, 254));
    send(CMD_WORD, run_word(3, 1'b1, 1));
    send(CMD_WORD, run_word(4, 1'b1, 1));
    send(CMD_WORD, run_word(6, 1'b0, 1));
    send(CMD_UNUSED, 16'hFFFF);
    send(CMD_WORD, header_word(3, PAD_BANK_END));
    send(CMD_WORD, run_word(8, 1'b0, 5));
    send(CMD_BANK, 16'hFFFF);
    send(CMD_EVENT, 16'h5A5A);
    send(CMD_WORD, run_word(0, 1'b0, 4));

    fill_one_pad();

    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame();
      end else if (pick < 70) begin
        send(CMD_BANK, WORD_W'($urandom_range(0, 65535)));
        send_frame();
      end else if (pick < 74 && events_sent < EVENT_BUDGET) begin
        send(CMD_EVENT, WORD_W'($urandom_range(0, 65535)));
      end else if (pick < 80) begin
        send(CMD_WORD, header_word($urandom_range(0, 127), PAD_BANK_END));
        ignored = $urandom_range(1, 3);
        repeat (ignored) send(CMD_WORD, WORD_W'($urandom_range(0, 65535)));
        send(CMD_BANK, WORD_W'($urandom_range(0, 65535)));
      end else if (pick < 92) begin
        pick = $urandom_range(0, 3);
        if (pick == CMD_EVENT && events_sent >= EVENT_BUDGET) begin
          pick = int'(CMD_WORD);
        end
        send(CMD_W'(pick), WORD_W'($urandom_range(0, 65535)));
        if (bank_over) begin
          send(CMD_BANK, WORD_W'($urandom_range(0, 65535)));
        end
      end else begin
        send(CMD_UNUSED, WORD_W'($urandom_range(0, 65535)));
        send(CMD_WORD, rand_run_word($urandom_range(0, 1)));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d decoded command transactions, %0d event clears and %0d samples,",
             items_sent, events_sent, samples_seen);
    $display("%0d of them flagged for a bad row or pad or a full pad list.", flagged_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
